// ===== hw/rtl/olss_pkg.sv =====
`timescale 1ns / 1ps
// Package for the ordered list store: operation codes, status codes and the
// command bundle that the control path broadcasts to every list cell.
// No dependencies.
package olss_pkg;

  localparam int DATA_W  = 32;
  localparam int KIND_W  = 2;
  localparam int POS_W   = 4;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  // Operation codes carried in the kind field.
  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE     = 2'd3;

  // Command broadcast from the control path to all cells.
  typedef struct packed {
    logic                     capture;   // transaction accepted this cycle
    logic                     commit;    // apply the held operation this cycle
    logic [KIND_W-1:0]        kind;      // held operation
    logic signed [DATA_W-1:0] cmp_value; // value compared at capture
    logic signed [DATA_W-1:0] wr_value;  // held value for an append
    logic [POS_W-1:0]         position;  // held read position
  } cell_cmd_t;

endpackage

// ===== hw/rtl/ordered_list_store_unit.sv =====
`timescale 1ns / 1ps
// Top level of the ordered list store: control path, result register and
// the chain of list cells. Depends on olss_pkg and olss_cell.
//
//   Channel | Handshake             | Payload
//   in      | in_valid / in_stall   | kind, value, position
//   out     | out_valid / out_stall | status, read_value, entry_count
//
// The accept cycle registers the match flag in every cell; the execute state
// then runs the match prefix and the read chain across the cells and applies
// the update, holding while the output register is full and stalled.
// Reset clears the count, the control state and the output valid flag; the
// entries and the result fields themselves are not cleared.
// A result waits in the output register; a following transaction is
// accepted meanwhile and holds in the execute state until that register frees.
module ordered_list_store_unit #(
  parameter int DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [olss_pkg::KIND_W-1:0]         kind,
  input  logic signed [olss_pkg::DATA_W-1:0]  value,
  input  logic [olss_pkg::POS_W-1:0]          position,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [olss_pkg::STAT_W-1:0]         status,
  output logic signed [olss_pkg::DATA_W-1:0]  read_value,
  output logic [olss_pkg::COUNT_W-1:0]        entry_count
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > olss_pkg::POS_W) ? CW : olss_pkg::POS_W;
  localparam int EW = (CW > olss_pkg::COUNT_W) ? CW : olss_pkg::COUNT_W;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic [0:0]                         state;
  logic [0:0]                         state_next;
  logic [CW-1:0]                      count;
  logic [CW-1:0]                      count_next;
  logic [olss_pkg::KIND_W-1:0]        op_kind;
  logic signed [olss_pkg::DATA_W-1:0] op_value;
  logic [olss_pkg::POS_W-1:0]         op_position;

  logic                               accept;
  logic                               commit;
  logic                               full;
  logic                               found;
  logic                               pos_ok;
  logic [olss_pkg::STAT_W-1:0]        status_next;
  logic signed [olss_pkg::DATA_W-1:0] read_next;
  logic [EW-1:0]                      count_ext;
  olss_pkg::cell_cmd_t                cmd;

  logic                               hit_chain [DEPTH+1];
  logic signed [olss_pkg::DATA_W-1:0] rd_chain  [DEPTH+1];
  logic signed [olss_pkg::DATA_W-1:0] cell_data [DEPTH];

  // Handshake and control.
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign commit   = (state == S_EXEC) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = S_EXEC;
      S_EXEC:  if (commit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the operation for the execute state.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_kind     <= kind;
      op_value    <= value;
      op_position <= position;
    end
  end

  assign cmd.capture   = accept;
  assign cmd.commit    = commit;
  assign cmd.kind      = op_kind;
  assign cmd.cmp_value = value;
  assign cmd.wr_value  = op_value;
  assign cmd.position  = op_position;

  // Cell chain.
  assign hit_chain[0]   = 1'b0;
  assign rd_chain[DEPTH] = '0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [olss_pkg::DATA_W-1:0] next_data;
    if (g == DEPTH - 1) begin : g_last
      assign next_data = '0;
    end else begin : g_mid
      assign next_data = cell_data[g+1];
    end
    olss_cell #(
      .CW    (CW),
      .INDEX (g)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .count     (count),
      .hit_in    (hit_chain[g]),
      .hit_out   (hit_chain[g+1]),
      .next_data (next_data),
      .data_out  (cell_data[g]),
      .rd_in     (rd_chain[g+1]),
      .rd_out    (rd_chain[g])
    );
  end

  // Result and count update.
  assign full   = (count == CW'(DEPTH));
  assign found  = hit_chain[DEPTH];
  assign pos_ok = (PW'(op_position) < PW'(count));

  always_comb begin
    status_next = olss_pkg::ST_OK;
    read_next   = '0;
    count_next  = count;
    case (op_kind)
      olss_pkg::KIND_APPEND: begin
        if (full) status_next = olss_pkg::ST_FULL;
        else count_next = count + 1'b1;
      end
      olss_pkg::KIND_REMOVE: begin
        if (found) count_next = count - 1'b1;
        else status_next = olss_pkg::ST_NOT_FOUND;
      end
      olss_pkg::KIND_READ: begin
        if (pos_ok) read_next = rd_chain[0];
        else status_next = olss_pkg::ST_RANGE;
      end
      default: begin
        status_next = olss_pkg::ST_OK;
      end
    endcase
  end

  assign count_ext = EW'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (commit) begin
      count <= count_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      status      <= status_next;
      read_value  <= read_next;
      entry_count <= count_ext[olss_pkg::COUNT_W-1:0];
    end
  end

  // Checks.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count exceeds list depth");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_EXEC))
    else $error("accepted transaction did not enter execution");

  a_append_grow: assert property (@(posedge clk) disable iff (rst)
    (commit && op_kind == olss_pkg::KIND_APPEND && !full)
      |=> (count == $past(count) + 1'b1))
    else $error("append did not grow the list");

  a_remove_shrink: assert property (@(posedge clk) disable iff (rst)
    (commit && op_kind == olss_pkg::KIND_REMOVE && found)
      |=> (count == $past(count) - 1'b1))
    else $error("remove did not shrink the list");

  a_commit_result: assert property (@(posedge clk) disable iff (rst)
    commit |=> out_valid)
    else $error("completed transaction produced no result");

endmodule

// ===== hw/rtl/olss_cell.sv =====
`timescale 1ns / 1ps
// One cell of the list chain: holds a single entry and its match flag.
// Depends on olss_pkg.
module olss_cell #(
  parameter int CW    = 5,
  parameter int INDEX = 0
) (
  input  logic                             clk,
  input  olss_pkg::cell_cmd_t              cmd,
  input  logic [CW-1:0]                    count,
  input  logic                             hit_in,
  output logic                             hit_out,
  input  logic signed [olss_pkg::DATA_W-1:0] next_data,
  output logic signed [olss_pkg::DATA_W-1:0] data_out,
  input  logic signed [olss_pkg::DATA_W-1:0] rd_in,
  output logic signed [olss_pkg::DATA_W-1:0] rd_out
);

  // A position beyond the read field can never be selected.
  localparam bit REACH = (INDEX < (1 << olss_pkg::POS_W));

  logic signed [olss_pkg::DATA_W-1:0] entry;
  logic                               hit;
  logic                               occupied;
  logic                               selected;

  assign occupied = (CW'(INDEX) < count);
  assign data_out = entry;

  // Match flag is taken when the transaction is accepted.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      hit <= occupied && (entry == cmd.cmp_value);
    end
  end

  // Prefix of matches: true from the first matching cell onwards.
  assign hit_out = hit_in | hit;

  // Append writes the cell at the tail; remove pulls every entry from the
  // first match onwards down by one place.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (cmd.kind == olss_pkg::KIND_APPEND && count == CW'(INDEX)) begin
        entry <= cmd.wr_value;
      end else if (cmd.kind == olss_pkg::KIND_REMOVE && hit_out) begin
        entry <= next_data;
      end
    end
  end

  // Read chain: the addressed cell puts its entry on the chain.
  assign selected = REACH && occupied && (cmd.position == olss_pkg::POS_W'(INDEX));
  assign rd_out   = selected ? entry : rd_in;

endmodule

// ===== dv/ordered_list_store_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for ordered_list_store_unit: a predictor of the
// ordered list checks every result transaction. Depends on olss_pkg and the
// ordered_list_store_unit RTL.
module ordered_list_store_unit_test;

  localparam int LIST_DEPTH   = 16;
  localparam int PHASE_ITEMS  = 330;
  localparam int POOL_SIZE    = 8;
  localparam int LONG_HOLD    = 150;
  localparam int HOLD_AT      = 100;
  localparam int SETTLE_TICKS = 8;

  // The kind code that the block ignores.
  localparam logic [olss_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [olss_pkg::KIND_W-1:0]        kind;
    logic signed [olss_pkg::DATA_W-1:0] value;
    logic [olss_pkg::POS_W-1:0]         position;
  } list_op_t;

  typedef struct packed {
    logic [olss_pkg::STAT_W-1:0]        status;
    logic signed [olss_pkg::DATA_W-1:0] read_value;
    logic [olss_pkg::COUNT_W-1:0]       entry_count;
  } list_result_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic [olss_pkg::KIND_W-1:0]        kind = '0;
  logic signed [olss_pkg::DATA_W-1:0] value = '0;
  logic [olss_pkg::POS_W-1:0]         position = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic [olss_pkg::STAT_W-1:0]        status;
  logic signed [olss_pkg::DATA_W-1:0] read_value;
  logic [olss_pkg::COUNT_W-1:0]       entry_count;

  list_op_t     pending_ops[$];
  list_result_t expected_results[$];

  // Predictor state: the list contents and the number of entries held.
  logic signed [olss_pkg::DATA_W-1:0] shadow_list[LIST_DEPTH];
  int                                 shadow_count = 0;

  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   hold_left      = 0;
  logic long_hold_done = 1'b0;
  int   ops_accepted   = 0;
  int   results_seen   = 0;
  int   error_count    = 0;
  int   full_hits      = 0;
  int   miss_hits      = 0;
  int   range_hits     = 0;
  int   good_reads     = 0;

  logic signed [olss_pkg::DATA_W-1:0] value_pool[POOL_SIZE];

  ordered_list_store_unit #(
    .DEPTH(LIST_DEPTH)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .value      (value),
    .position   (position),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .read_value (read_value),
    .entry_count(entry_count)
  );

  // Free-running clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Applies one operation to the shadow list and returns the result it yields.
  function automatic list_result_t apply_list_op(list_op_t op);
    list_result_t res;
    int           hit;
    res.status      = olss_pkg::ST_OK;
    res.read_value  = '0;
    hit             = -1;
    case (op.kind)
      olss_pkg::KIND_APPEND: begin
        if (shadow_count >= LIST_DEPTH) begin
          res.status = olss_pkg::ST_FULL;
          full_hits++;
        end else begin
          shadow_list[shadow_count] = op.value;
          shadow_count++;
        end
      end
      olss_pkg::KIND_REMOVE: begin
        for (int i = 0; i < shadow_count; i++) begin
          if (hit < 0 && shadow_list[i] == op.value) hit = i;
        end
        if (hit < 0) begin
          res.status = olss_pkg::ST_NOT_FOUND;
          miss_hits++;
        end else begin
          // Close the gap so the remaining order is kept.
          for (int i = hit; i + 1 < shadow_count; i++) begin
            shadow_list[i] = shadow_list[i + 1];
          end
          shadow_count--;
        end
      end
      olss_pkg::KIND_READ: begin
        if (int'(op.position) < shadow_count) begin
          res.read_value = shadow_list[op.position];
          good_reads++;
        end else begin
          res.status = olss_pkg::ST_RANGE;
          range_hits++;
        end
      end
      default: begin
      end
    endcase
    res.entry_count = olss_pkg::COUNT_W'(shadow_count);
    return res;
  endfunction

  // Sender: presents queued operations and predicts each accepted transaction.
  always @(posedge clk) begin : send_proc
    list_op_t op;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        op.kind     = kind;
        op.value    = value;
        op.position = position;
        expected_results.push_back(apply_list_op(op));
        ops_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          op       = pending_ops.pop_front();
          in_valid <= 1'b1;
          kind     <= op.kind;
          value    <= op.value;
          position <= op.position;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stalls at random, holds off once for a long stretch, and checks
  // every result transaction against the oldest prediction.
  always @(posedge clk) begin : recv_proc
    list_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t: result with nothing expected: status %0d value %0d count %0d",
                   $time, status, read_value, entry_count);
        end else begin
          want = expected_results.pop_front();
          if (status !== want.status) begin
            error_count++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
          end
          if (read_value !== want.read_value) begin
            error_count++;
            $display("%0t: read_value expected %0d actual %0d",
                     $time, want.read_value, read_value);
          end
          if (entry_count !== want.entry_count) begin
            error_count++;
            $display("%0t: entry_count expected %0d actual %0d",
                     $time, want.entry_count, entry_count);
          end
        end
      end
      // The long hold starts only once in the whole run.
      if (!long_hold_done && results_seen == HOLD_AT) begin
        long_hold_done <= 1'b1;
        hold_left      <= LONG_HOLD;
        out_stall      <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  task automatic queue_op(logic [olss_pkg::KIND_W-1:0] k,
                          logic signed [olss_pkg::DATA_W-1:0] v,
                          logic [olss_pkg::POS_W-1:0] p);
    list_op_t op;
    op.kind     = k;
    op.value    = v;
    op.position = p;
    pending_ops.push_back(op);
  endtask

  // Waits until every queued transaction has been sent and answered.
  task automatic wait_for_drain();
    do @(negedge clk);
    while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  // Stimulus: a directed sequence, then three phases of random operations.
  initial begin : stim_proc
    logic                               filling;
    int                                 pick;
    int                                 append_cut;
    int                                 remove_cut;
    logic [olss_pkg::KIND_W-1:0]        k;
    logic signed [olss_pkg::DATA_W-1:0] v;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Empty list, head removal, out of range, unused kind, then fill past full.
    queue_op(olss_pkg::KIND_READ,   32'sd0, 4'd0);
    queue_op(olss_pkg::KIND_REMOVE, 32'sd5, 4'd0);
    queue_op(olss_pkg::KIND_APPEND, 32'sh8000_0000, 4'd15);
    queue_op(olss_pkg::KIND_APPEND, 32'sh7fff_ffff, 4'd0);
    queue_op(olss_pkg::KIND_APPEND, 32'sd0, 4'd0);
    queue_op(olss_pkg::KIND_READ,   32'sd0, 4'd3);
    queue_op(olss_pkg::KIND_REMOVE, 32'sh8000_0000, 4'd0);
    queue_op(olss_pkg::KIND_READ,   -32'sd1, 4'd0);
    queue_op(olss_pkg::KIND_REMOVE, 32'sd12345, 4'd0);
    queue_op(KIND_UNUSED, -32'sd1, 4'd15);
    for (int i = 0; i < 15; i++) begin
      queue_op(olss_pkg::KIND_APPEND, -32'sd1 - i, 4'd0);
    end
    queue_op(olss_pkg::KIND_READ, 32'sd0, 4'd15);
    wait_for_drain();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 25; recv_stall_pct = 82; end
        1: begin send_idle_pct = 82; recv_stall_pct = 25; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      // A small pool of values so that removals usually find a match.
      value_pool[0] = 32'sh8000_0000;
      value_pool[1] = 32'sh7fff_ffff;
      value_pool[2] = -32'sd1;
      value_pool[3] = 32'sd0;
      for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom;
      filling = 1'b0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Alternate between bursts that fill the list and bursts that empty it.
        if (i % 40 == 0) filling = !filling;
        append_cut = filling ? 62 : 27;
        remove_cut = filling ? 77 : 72;
        pick = $urandom_range(99);
        if (pick < 2) k = KIND_UNUSED;
        else if (pick < append_cut) k = olss_pkg::KIND_APPEND;
        else if (pick < remove_cut) k = olss_pkg::KIND_REMOVE;
        else k = olss_pkg::KIND_READ;
        if ($urandom_range(99) < 75) v = value_pool[$urandom_range(POOL_SIZE - 1)];
        else v = $urandom;
        queue_op(k, v, olss_pkg::POS_W'($urandom_range(15)));
      end
      wait_for_drain();
    end

    repeat (SETTLE_TICKS) @(posedge clk);
    $display("Covered %0d transactions and %0d results: %0d full, %0d not found,",
             ops_accepted, results_seen, full_hits, miss_hits);
    $display("%0d out of range and %0d good reads.", range_hits, good_reads);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
